// File: hdl/chull_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_pkg: shared constants and types for the convex hull block
// Capacity, coordinate width and the channel payload types.
// ----------------------------------------------------------------------------
package chull_pkg;
    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int STK_W       = $clog2(MAX_POINTS + 2);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] pz;
        logic                          last_point;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] hx;
        logic signed [COORD_WIDTH-1:0] hz;
        logic                          last_vertex;
        logic                          points_dropped;
    } t_vertex;
endpackage

// File: hdl/chull_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_point_if / chull_vertex_if: valid/ready channels
// Input point channel and output hull vertex channel.
// ----------------------------------------------------------------------------
interface chull_point_if;
    logic               valid;
    logic               ready;
    chull_pkg::t_point  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface chull_vertex_if;
    logic               valid;
    logic               ready;
    chull_pkg::t_vertex data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/convex_hull_2d_monotone_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_2d_monotone_chain: convex hull of a planar point set
// Stores up to MAX_POINTS points, sorts them and walks the monotone chain.
// ----------------------------------------------------------------------------
// Points load one per cycle. After the transfer carrying last_point the block
// stops accepting points. An insertion sort then runs one compare at a time.
// The lower and upper chains are then built with one shared cross-product
// unit; each turn test runs stack and store reads, then differences, two
// multiplies and the compare. The hull is emitted counter-clockwise from the
// least point, one vertex at a time: the next vertex is read from the stack
// and store only after the one before has gone into the output register.
// Sets of fewer than three points are emitted in arrival order. Points beyond
// capacity are discarded and flagged on every vertex. Loading resumes as soon
// as the last vertex sits in the output register.
// ----------------------------------------------------------------------------
module convex_hull_2d_monotone_chain (
    input  logic i_clk,
    input  logic i_rst_n,
    chull_point_if.sink    i_pt,
    chull_vertex_if.source o_hull
);
    import chull_pkg::*;

    localparam logic [4:0] S_LOAD    = 5'd0,  S_SORT_I  = 5'd1,  S_SORT_V  = 5'd2,
                           S_SORT_R  = 5'd3,  S_SORT_C  = 5'd4,  S_SORT_A  = 5'd5,
                           S_SORT_X  = 5'd6,  S_SORT_T  = 5'd7,  S_SORT_W  = 5'd8,
                           S_HULL_I  = 5'd9,  S_HULL_O  = 5'd10, S_HULL_D  = 5'd11,
                           S_RD0     = 5'd12, S_RDB     = 5'd13, S_RDO     = 5'd14,
                           S_RD1     = 5'd15, S_RD2     = 5'd16, S_DIFF    = 5'd17,
                           S_MUL1    = 5'd18, S_MUL2    = 5'd19, S_CMP     = 5'd20,
                           S_PUSH    = 5'd21, S_OUT_R   = 5'd22, S_OUT_A   = 5'd23,
                           S_OUT_V   = 5'd24, S_OUT_X   = 5'd25, S_OUT_E   = 5'd26,
                           S_SMALL   = 5'd27, S_SMALL_X = 5'd28, S_SMALL_E = 5'd29;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    // point stores, sort order and hull stack
    logic signed [COORD_WIDTH-1:0] r_xs [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] r_zs [MAX_POINTS];
    logic [IDX_W-1:0] r_ord [MAX_POINTS];
    logic [IDX_W-1:0] r_stk [MAX_POINTS+1];

    logic [4:0]       r_st;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [CNT_W-1:0] r_i, r_j;
    logic [STK_W-1:0] r_k, r_t;
    logic             r_upper;
    logic [IDX_W-1:0] r_v, r_prev, r_cand;
    logic signed [COORD_WIDTH-1:0] r_ax, r_az, r_bx, r_bz;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oz;
    logic signed [DW-1:0] r_d0, r_d1, r_d2, r_d3;
    logic signed [PW-1:0] r_p1, r_p2;
    logic [IDX_W-1:0] r_ra;
    logic signed [COORD_WIDTH-1:0] r_rx, r_rz;
    logic [IDX_W-1:0] r_ro, r_rs;
    logic             r_ovalid;
    t_vertex          r_odata;

    // shared multiplier operands
    logic signed [DW-1:0] m_a, m_b;
    logic signed [PW-1:0] m_p;
    assign m_a = (r_st == S_MUL1) ? r_d0 : r_d1;
    assign m_b = (r_st == S_MUL1) ? r_d3 : r_d2;
    assign m_p = m_a * m_b;

    logic in_xfer, out_xfer;
    assign i_pt.ready   = (r_st == S_LOAD);
    assign in_xfer      = i_pt.valid && i_pt.ready;
    assign o_hull.valid = r_ovalid;
    assign o_hull.data  = r_odata;
    assign out_xfer     = r_ovalid && o_hull.ready;

    // a new vertex goes into the output register when it is free
    logic emit;
    assign emit = ((r_st == S_OUT_E) || (r_st == S_SMALL_E)) && (!r_ovalid || out_xfer);

    logic [CNT_W-1:0] n_cnt;
    assign n_cnt = r_cnt + CNT_W'(1);

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_rx <= r_xs[r_ra];
        r_rz <= r_zs[r_ra];
        r_ro <= r_ord[r_j[IDX_W-1:0]];
        r_rs <= r_stk[r_k[$clog2(MAX_POINTS+1)-1:0]];
        if (in_xfer && r_cnt < CNT_W'(MAX_POINTS)) begin
            r_xs[r_cnt[IDX_W-1:0]] <= i_pt.data.px;
            r_zs[r_cnt[IDX_W-1:0]] <= i_pt.data.pz;
        end
    end

    logic less;
    assign less = (r_ax < r_rx) || (r_ax == r_rx && r_az < r_rz);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (emit) r_ovalid <= 1'b1;
            else if (out_xfer) r_ovalid <= 1'b0;
            unique case (r_st)
                S_LOAD: if (in_xfer) begin
                    if (r_cnt < CNT_W'(MAX_POINTS)) r_cnt <= n_cnt;
                    else r_ovf <= 1'b1;
                    if (i_pt.data.last_point) begin
                        r_i <= '0;
                        if ((r_cnt < CNT_W'(MAX_POINTS) ? n_cnt : r_cnt) < CNT_W'(3))
                            r_st <= S_SMALL;
                        else r_st <= S_SORT_I;
                    end
                end
                // insertion sort: key v against ord[j-1]
                S_SORT_I: begin
                    if (r_i == r_cnt) begin
                        r_k <= '0; r_i <= '0; r_upper <= 1'b0; r_st <= S_HULL_I;
                    end else begin
                        r_v <= r_i[IDX_W-1:0]; r_ra <= r_i[IDX_W-1:0]; r_j <= r_i;
                        r_st <= S_SORT_V;
                    end
                end
                S_SORT_V: begin
                    r_st <= S_SORT_R;
                end
                S_SORT_R: begin
                    r_ax <= r_rx; r_az <= r_rz;
                    if (r_j == '0) r_st <= S_SORT_W;
                    else begin r_j <= r_j - CNT_W'(1); r_st <= S_SORT_C; end
                end
                // order entry j-1 lands in r_ro
                S_SORT_C: r_st <= S_SORT_A;
                S_SORT_A: begin
                    r_ra <= r_ro; r_prev <= r_ro; r_st <= S_SORT_X;
                end
                S_SORT_X: r_st <= S_SORT_T;
                S_SORT_T: begin
                    if (less) begin
                        r_ord[r_j[IDX_W-1:0] + IDX_W'(1)] <= r_prev;
                        if (r_j == '0) r_st <= S_SORT_W;
                        else begin r_j <= r_j - CNT_W'(1); r_st <= S_SORT_C; end
                    end else begin
                        r_j <= r_j + CNT_W'(1); r_st <= S_SORT_W;
                    end
                end
                S_SORT_W: begin
                    r_ord[r_j[IDX_W-1:0]] <= r_v;
                    r_i <= r_i + CNT_W'(1); r_st <= S_SORT_I;
                end
                // hull walk: pick candidate
                S_HULL_I: begin
                    if (!r_upper && r_i == r_cnt) begin
                        r_upper <= 1'b1; r_t <= r_k + STK_W'(1);
                        r_i <= r_cnt - CNT_W'(1);
                    end else if (r_upper && r_i == '0) begin
                        r_k <= (r_k > '0) ? r_k - STK_W'(1) : '0;
                        r_i <= '0; r_st <= S_OUT_R;
                    end else begin
                        r_j <= r_upper ? r_i - CNT_W'(1) : r_i;
                        r_st <= S_HULL_O;
                    end
                end
                S_HULL_O: r_st <= S_HULL_D;
                S_HULL_D: begin
                    r_cand <= r_ro;
                    if ((!r_upper && r_k >= STK_W'(2)) || (r_upper && r_k >= r_t)) begin
                        r_ra <= r_ro; r_k <= r_k - STK_W'(2); r_st <= S_RD0;
                    end else r_st <= S_PUSH;
                end
                S_RD0: begin r_k <= r_k + STK_W'(1); r_st <= S_RDB; end
                S_RDB: begin r_bx <= r_rx; r_bz <= r_rz; r_ra <= r_rs; r_st <= S_RDO; end
                S_RDO: begin r_ra <= r_rs; r_k <= r_k + STK_W'(1); r_st <= S_RD1; end
                S_RD1: begin r_ox <= r_rx; r_oz <= r_rz; r_st <= S_RD2; end
                S_RD2: begin r_ax <= r_rx; r_az <= r_rz; r_st <= S_DIFF; end
                S_DIFF: begin
                    r_d0 <= DW'(r_ax) - DW'(r_ox); r_d1 <= DW'(r_az) - DW'(r_oz);
                    r_d2 <= DW'(r_bx) - DW'(r_ox); r_d3 <= DW'(r_bz) - DW'(r_oz);
                    r_st <= S_MUL1;
                end
                S_MUL1: begin r_p1 <= m_p; r_st <= S_MUL2; end
                S_MUL2: begin r_p2 <= m_p; r_st <= S_CMP; end
                S_CMP: begin
                    if (r_p1 <= r_p2) begin r_k <= r_k - STK_W'(1); r_st <= S_HULL_D; end
                    else begin r_st <= S_PUSH; end
                end
                S_PUSH: begin
                    if (r_k < STK_W'(MAX_POINTS + 1)) begin
                        r_stk[r_k[$clog2(MAX_POINTS+1)-1:0]] <= r_cand;
                        r_k <= r_k + STK_W'(1);
                    end
                    r_i <= r_upper ? r_i - CNT_W'(1) : r_i + CNT_W'(1);
                    r_st <= S_HULL_I;
                end
                // emit hull from the stack
                S_OUT_R: begin
                    r_t <= r_k; r_k <= STK_W'(r_i); r_st <= S_OUT_A;
                end
                S_OUT_A: begin r_st <= S_OUT_V; end
                S_OUT_V: begin r_ra <= r_rs; r_st <= S_OUT_X; end
                S_OUT_X: r_st <= S_OUT_E;
                S_OUT_E: if (emit) begin
                    r_odata.hx <= r_rx; r_odata.hz <= r_rz; r_odata.points_dropped <= r_ovf;
                    r_odata.last_vertex <= (r_i + CNT_W'(1) == CNT_W'(r_t))
                                        || (r_i + CNT_W'(1) == CNT_W'(MAX_POINTS));
                    if (r_i + CNT_W'(1) == CNT_W'(r_t) ||
                        r_i + CNT_W'(1) == CNT_W'(MAX_POINTS)) begin
                        r_cnt <= '0; r_ovf <= 1'b0; r_st <= S_LOAD;
                    end else begin
                        r_i <= r_i + CNT_W'(1); r_k <= STK_W'(r_i + CNT_W'(1));
                        r_st <= S_OUT_A;
                    end
                end
                S_SMALL: begin
                    r_ra <= r_i[IDX_W-1:0]; r_st <= S_SMALL_X;
                end
                S_SMALL_X: r_st <= S_SMALL_E;
                S_SMALL_E: if (emit) begin
                    r_odata.hx <= r_rx; r_odata.hz <= r_rz; r_odata.points_dropped <= r_ovf;
                    r_odata.last_vertex <= (r_i + CNT_W'(1) == r_cnt);
                    if (r_i + CNT_W'(1) == r_cnt) begin
                        r_cnt <= '0; r_ovf <= 1'b0; r_st <= S_LOAD;
                    end else begin
                        r_i <= r_i + CNT_W'(1); r_st <= S_SMALL;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end
endmodule

// File: hdl/chull_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_checker: port-level checks for the convex hull block
// Handshake stability, load/emit exclusion and output state after reset.
// ----------------------------------------------------------------------------
module chull_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input chull_pkg::t_vertex i_out_data
);
    // a stalled vertex stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("vertex dropped");
    // a stalled vertex keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("vertex changed while stalled");
    // no point transfer while a vertex other than the last waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last_vertex |-> !(i_in_valid && i_in_ready))
        else $error("load during emit");
    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("vertex offered after reset");
endmodule

bind convex_hull_2d_monotone_chain chull_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_pt.valid), .i_in_ready(i_pt.ready),
    .i_out_valid(o_hull.valid), .i_out_ready(o_hull.ready),
    .i_out_data(o_hull.data)
);

// File: tb/convex_hull_2d_monotone_chain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_2d_monotone_chain_tb: self-checking regression for the hull block
// Sends point sets through the point channel, predicts each hull with a local
// monotone chain model and checks every vertex transfer against it.
// ----------------------------------------------------------------------------
module convex_hull_2d_monotone_chain_tb;
    import chull_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    chull_point_if  pt_if ();
    chull_vertex_if hull_if ();

    convex_hull_2d_monotone_chain u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_hull  (hull_if.source)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [COORD_WIDTH-1:0] set_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] set_z [MAX_POINTS];
    int      set_count;
    bit      set_overflow;
    t_vertex hull_expected [$];

    int  errors = 0;
    int  points_sent;
    int  hulls_seen = 0;
    int  vertices_seen = 0;
    int  idle_cycles = 0;
    int  sink_stall = 0;
    bit  sink_busy_allowed;

    function automatic bit point_less(int a, int b);
        if (set_x[a] != set_x[b]) return set_x[a] < set_x[b];
        return set_z[a] < set_z[b];
    endfunction

    // Cross product (a-o) x (b-o) is zero or negative
    function automatic bit turn_not_left(int o, int a, int b);
        longint ax, az, bx, bz;
        ax = longint'(set_x[a]) - longint'(set_x[o]);
        az = longint'(set_z[a]) - longint'(set_z[o]);
        bx = longint'(set_x[b]) - longint'(set_x[o]);
        bz = longint'(set_z[b]) - longint'(set_z[o]);
        return (ax * bz) <= (az * bx);
    endfunction

    // Append one vertex to the expected queue
    function automatic void add_expected(t_vertex vx);
        hull_expected.insert(hull_expected.size(), vx);
    endfunction

    // Take one accepted point; on the last one queue the expected hull
    task automatic predict_point(t_point p);
        int order [MAX_POINTS];
        int stk [MAX_POINTS + 1];
        int n, k, t, j, v;
        t_vertex vx;
        if (set_count < MAX_POINTS) begin
            set_x[set_count] = p.px;
            set_z[set_count] = p.pz;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!p.last_point) return;
        n = set_count;
        if (n < 3) begin
            for (int i = 0; i < n; i++) begin
                vx.hx = set_x[i]; vx.hz = set_z[i];
                vx.last_vertex = (i + 1 == n); vx.points_dropped = set_overflow;
                add_expected(vx);
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                v = i; j = i;
                while (j > 0 && point_less(v, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = v;
            end
            k = 0;
            for (int i = 0; i < n; i++) begin
                while (k >= 2 && turn_not_left(stk[k-2], stk[k-1], order[i])) k--;
                if (k < MAX_POINTS + 1) stk[k++] = order[i];
            end
            t = k + 1;
            for (int i = n - 1; i > 0; i--) begin
                while (k >= t && turn_not_left(stk[k-2], stk[k-1], order[i-1])) k--;
                if (k < MAX_POINTS + 1) stk[k++] = order[i-1];
            end
            k = (k > 0) ? k - 1 : 0;
            for (int i = 0; i < k && i < MAX_POINTS; i++) begin
                vx.hx = set_x[stk[i]]; vx.hz = set_z[stk[i]];
                vx.last_vertex = (i + 1 == k) || (i + 1 == MAX_POINTS);
                vx.points_dropped = set_overflow;
                add_expected(vx);
            end
        end
        set_count = 0;
        set_overflow = 1'b0;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Send one point and wait for its transfer; valid stays high afterwards
    task automatic send_point(logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] z, bit last);
        int gap;
        t_point p;
        gap = gap_len();
        p.px = x; p.pz = z; p.last_point = last;
        if (gap != 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data  <= p;
        do @(posedge i_clk); while (!pt_if.ready);
        predict_point(p);
        points_sent++;
    endtask

    // Wait for the hull of the last set to drain
    task automatic drain_hull();
        pt_if.valid <= 1'b0;
        while (hull_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return COORD_WIDTH'($urandom_range(0, 15)) - 16'sd8;
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    // Directed: extremes, small sets, collinear, duplicates
    task automatic test_directed();
        send_point(16'sh1234, -16'sh0100, 1'b1);
        drain_hull();
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b1);
        drain_hull();
        // Extreme square
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b1);
        drain_hull();
        // Collinear line
        for (int i = 0; i < 5; i++) send_point(16'(i * 3), 16'(i * 2), i == 4);
        drain_hull();
        // All equal
        for (int i = 0; i < 4; i++) send_point(-16'sd5, 16'sd9, i == 3);
        drain_hull();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_POINTS + 3; i++)
            send_point(rand_coord(), rand_coord(), i == MAX_POINTS + 2);
        drain_hull();
    endtask

    task automatic test_random_sets();
        int n;
        while (points_sent < 410) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), i == n - 1);
            drain_hull();
        end
    endtask

    // Sink ready with random stalls, mostly short and now and then long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hull_if.ready <= 1'b0;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            hull_if.ready <= 1'b0;
            sink_stall--;
        end else if (sink_busy_allowed && $urandom_range(0, 3) == 0) begin
            hull_if.ready <= 1'b0;
            sink_stall = gap_len();
        end else begin
            hull_if.ready <= 1'b1;
        end
    end

    // Vertex checker
    always @(posedge i_clk) begin
        t_vertex got, want;
        if (i_rst_n && hull_if.valid && hull_if.ready) begin
            got = hull_if.data;
            vertices_seen++;
            if (hull_expected.size() == 0) begin
                $error("unexpected vertex x=%0d z=%0d", got.hx, got.hz);
                errors++;
            end else begin
                want = hull_expected.pop_front();
                if (got.hx != want.hx) begin
                    $error("hx expected %0d actual %0d", want.hx, got.hx); errors++;
                end
                if (got.hz != want.hz) begin
                    $error("hz expected %0d actual %0d", want.hz, got.hz); errors++;
                end
                if (got.last_vertex != want.last_vertex) begin
                    $error("last_vertex expected %0b actual %0b",
                           want.last_vertex, got.last_vertex); errors++;
                end
                if (got.points_dropped != want.points_dropped) begin
                    $error("points_dropped expected %0b actual %0b",
                           want.points_dropped, got.points_dropped); errors++;
                end
                if (want.last_vertex) hulls_seen++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (hull_if.valid && hull_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("convex_hull_2d_monotone_chain regression: fail");
            $finish;
        end
    end

    initial begin
        points_sent = 0; set_count = 0; set_overflow = 1'b0;
        sink_busy_allowed = 1'b1;
        pt_if.valid = 1'b0;
        pt_if.data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random_sets();
        sink_busy_allowed = 1'b0;
        drain_hull();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d points, %0d hulls, %0d vertices checked.",
                 points_sent, hulls_seen, vertices_seen);
        if (errors == 0 && hull_expected.size() == 0)
            $display("convex_hull_2d_monotone_chain regression: pass");
        else
            $display("convex_hull_2d_monotone_chain regression: fail");
        $finish;
    end
endmodule
